// File: rtl/core/mfc_pkg.sv
package mfc_pkg;

	// field widths
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 6;
	localparam int MASK_W  = 6;
	localparam int ADDR_W  = 32;
	localparam int PROTO_W = 8;
	localparam int PORT_W  = 16;

	// table depth
	localparam int FLOW_ENTRIES_DEF = 64;

	// word kinds
	localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

	// protocol numbers
	localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

	// mask bit positions
	localparam int MB_ADDR_SRC = 0;
	localparam int MB_ADDR_DST = 1;
	localparam int MB_TCP_SRC  = 2;
	localparam int MB_TCP_DST  = 3;
	localparam int MB_UDP_SRC  = 4;
	localparam int MB_UDP_DST  = 5;

	// request word as it travels down the chain
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] entry_index;
		logic [MASK_W-1:0]  entry_mask;
		logic [ADDR_W-1:0]  addr_src;
		logic [ADDR_W-1:0]  addr_dst;
		logic [PROTO_W-1:0] ip_protocol;
		logic [PORT_W-1:0]  port_src;
		logic [PORT_W-1:0]  port_dst;
	} flow_word_t;

	// running search result
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] flow_index;
	} search_t;

endpackage

// File: rtl/core/mfc_if.sv
interface mfc_req_if import mfc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [INDEX_W-1:0] entry_index;
	logic [MASK_W-1:0]  entry_mask;
	logic [ADDR_W-1:0]  addr_src;
	logic [ADDR_W-1:0]  addr_dst;
	logic [PROTO_W-1:0] ip_protocol;
	logic [PORT_W-1:0]  port_src;
	logic [PORT_W-1:0]  port_dst;

	modport source (
		output valid, kind, entry_index, entry_mask, addr_src, addr_dst,
			ip_protocol, port_src, port_dst,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, entry_mask, addr_src, addr_dst,
			ip_protocol, port_src, port_dst,
		output ready
	);
endinterface

interface mfc_rsp_if import mfc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [INDEX_W-1:0] flow_index;

	modport source (
		output valid, hit, flow_index,
		input  ready
	);
	modport sink (
		input  valid, hit, flow_index,
		output ready
	);
endinterface

// File: rtl/core/mfc_cell.sv
module mfc_cell import mfc_pkg::*; #(
	parameter int CELL_INDEX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  flow_word_t in_word,
	input  search_t    in_res,
	output logic       out_valid,
	output flow_word_t out_word,
	output search_t    out_res
);

	logic               entry_valid_q;
	logic [MASK_W-1:0]  mask_q;
	logic [ADDR_W-1:0]  addr_src_q;
	logic [ADDR_W-1:0]  addr_dst_q;
	logic [PORT_W-1:0]  port_src_q;
	logic [PORT_W-1:0]  port_dst_q;

	logic               out_valid_q;
	flow_word_t         word_q;
	search_t            res_q;

	logic               sel;
	logic               do_write;
	logic               do_clear;
	logic               ok_addr;
	logic               ok_tcp;
	logic               ok_udp;
	logic               match;
	search_t            res_d;

	// entry addressed by this word
	assign sel      = en && in_valid && (int'(in_word.entry_index) == CELL_INDEX);
	assign do_write = sel && (in_word.kind == KIND_WRITE);
	assign do_clear = sel && (in_word.kind == KIND_CLEAR);

	// masked compare against the stored entry
	always_comb begin
		ok_addr = (!mask_q[MB_ADDR_SRC] || (addr_src_q == in_word.addr_src)) &&
			(!mask_q[MB_ADDR_DST] || (addr_dst_q == in_word.addr_dst));
		ok_tcp = !(mask_q[MB_TCP_SRC] || mask_q[MB_TCP_DST]) ||
			((in_word.ip_protocol == PROTO_TCP) &&
			(!mask_q[MB_TCP_SRC] || (port_src_q == in_word.port_src)) &&
			(!mask_q[MB_TCP_DST] || (port_dst_q == in_word.port_dst)));
		ok_udp = !(mask_q[MB_UDP_SRC] || mask_q[MB_UDP_DST]) ||
			((in_word.ip_protocol == PROTO_UDP) &&
			(!mask_q[MB_UDP_SRC] || (port_src_q == in_word.port_src)) &&
			(!mask_q[MB_UDP_DST] || (port_dst_q == in_word.port_dst)));
		match = entry_valid_q && ok_addr && ok_tcp && ok_udp;
	end

	// first hit wins, later cells keep it
	always_comb begin
		res_d = in_res;
		if ((in_word.kind == KIND_CLASSIFY) && !in_res.hit && match) begin
			res_d.hit        = 1'b1;
			res_d.flow_index = INDEX_W'(CELL_INDEX);
		end
	end

	// entry valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else if (do_write) begin
			entry_valid_q <= 1'b1;
		end else if (do_clear) begin
			entry_valid_q <= 1'b0;
		end
	end

	// entry key and mask
	always_ff @(posedge clk) begin
		if (do_write) begin
			mask_q     <= in_word.entry_mask;
			addr_src_q <= in_word.addr_src;
			addr_dst_q <= in_word.addr_dst;
			port_src_q <= in_word.port_src;
			port_dst_q <= in_word.port_dst;
		end
	end

	// hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= in_word;
			res_q  <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = word_q;
	assign out_res   = res_q;

endmodule

// File: rtl/core/masked_flow_classifier_unit.sv
// channel  dir  payload                                             handshake
// req      in   kind, entry_index, entry_mask, addr_src, addr_dst,  valid/ready
//               ip_protocol, port_src, port_dst
// rsp      out  hit, flow_index                                     valid/ready
//
// one word enters per cycle while the chain is not stalled; a word passes one cell
// per cycle, so rsp.valid for a classify rises once its word has passed the
// register of every cell, and the result is taken when rsp.ready is high
// writes and clears act when they reach their cell and give no result
// arst_n clears every entry's valid mark and the chain's valid bits
// a result held at the end of the chain with rsp.ready low stalls the whole chain
module masked_flow_classifier_unit import mfc_pkg::*; #(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mfc_req_if.sink   req,
	mfc_rsp_if.source rsp
);

	logic       en;
	logic       stg_valid [0:FLOW_ENTRIES];
	flow_word_t stg_word  [0:FLOW_ENTRIES];
	search_t    stg_res   [0:FLOW_ENTRIES];
	logic       out_is_result;

	// chain head
	assign stg_valid[0]            = req.valid;
	assign stg_word[0].kind        = req.kind;
	assign stg_word[0].entry_index = req.entry_index;
	assign stg_word[0].entry_mask  = req.entry_mask;
	assign stg_word[0].addr_src    = req.addr_src;
	assign stg_word[0].addr_dst    = req.addr_dst;
	assign stg_word[0].ip_protocol = req.ip_protocol;
	assign stg_word[0].port_src    = req.port_src;
	assign stg_word[0].port_dst    = req.port_dst;
	assign stg_res[0]              = '0;

	// row of entry cells
	for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
		mfc_cell #(
			.CELL_INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (stg_valid[i]),
			.in_word  (stg_word[i]),
			.in_res   (stg_res[i]),
			.out_valid(stg_valid[i+1]),
			.out_word (stg_word[i+1]),
			.out_res  (stg_res[i+1])
		);
	end

	// chain tail: only classify words carry a result
	assign out_is_result = stg_valid[FLOW_ENTRIES] &&
		(stg_word[FLOW_ENTRIES].kind == KIND_CLASSIFY);
	assign en = !out_is_result || rsp.ready;

	assign req.ready      = en;
	assign rsp.valid      = out_is_result;
	assign rsp.hit        = stg_res[FLOW_ENTRIES].hit;
	assign rsp.flow_index = stg_res[FLOW_ENTRIES].flow_index;

endmodule
